// ===== rtl/core/hamming_sec_codec_defines.svh =====
// Assertion macros for the port-level checker of the Hamming codec.
// The macros expect clk_i and rst_ni to be visible where they are used.
`ifndef HAMMING_SEC_CODEC_DEFINES_SVH
`define HAMMING_SEC_CODEC_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HSC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/hsc_pkg.sv =====
// Package for the Hamming single-error-correcting codec.
// Holds the code geometry, the item and result types and the bit-mapping helpers.
`default_nettype none

package hsc_pkg;

  localparam int PARITY_BITS = 6;
  localparam int CODE_LEN    = (1 << PARITY_BITS) - 1;
  localparam int DATA_LEN    = CODE_LEN - PARITY_BITS;

  // Port field widths are fixed for the largest supported code.
  localparam int CODE_W      = 63;
  localparam int DATA_W      = 57;
  localparam int SYN_W       = 6;
  localparam int S_TDATA_W   = 120;
  localparam int M_TDATA_W   = 128;
  localparam int M_PAD_W     = M_TDATA_W - CODE_W - DATA_W - SYN_W;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  // Word is the scattered data on encode, the masked received word on decode.
  typedef struct packed {
    op_e               op;
    logic [CODE_W-1:0] word;
  } item_t;

  typedef struct packed {
    logic [SYN_W-1:0]  syndrome;
    logic [DATA_W-1:0] data_out;
    logic [CODE_W-1:0] code_word;
  } result_t;

  function automatic logic is_pow2(int p);
    return (p & (p - 1)) == 0;
  endfunction

  // Positions 1..CODE_LEN that take part in the code.
  function automatic logic [CODE_W-1:0] code_mask();
    logic [CODE_W-1:0] m;
    m = '0;
    for (int p = 1; p <= CODE_LEN; p++) begin
      m[p-1] = 1'b1;
    end
    return m;
  endfunction

  // Positions whose index has bit j set, the parity position included.
  function automatic logic [CODE_W-1:0] par_mask(int j);
    logic [CODE_W-1:0] m;
    m = '0;
    for (int p = 1; p <= CODE_LEN; p++) begin
      if (((p >> j) & 1) != 0) begin
        m[p-1] = 1'b1;
      end
    end
    return m;
  endfunction

  // Places data bits in the non-power-of-two positions, in ascending order.
  function automatic logic [CODE_W-1:0] scatter(logic [DATA_W-1:0] data);
    logic [CODE_W-1:0] cw;
    int                di;
    cw = '0;
    di = 0;
    for (int p = 1; p <= CODE_LEN; p++) begin
      if (!is_pow2(p)) begin
        cw[p-1] = data[di];
        di++;
      end
    end
    return cw;
  endfunction

  function automatic logic [DATA_W-1:0] extract(logic [CODE_W-1:0] cw);
    logic [DATA_W-1:0] data;
    int                di;
    data = '0;
    di   = 0;
    for (int p = 1; p <= CODE_LEN; p++) begin
      if (!is_pow2(p)) begin
        data[di] = cw[p-1];
        di++;
      end
    end
    return data;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hamming_sec_codec.sv =====
// Hamming single-error-correcting codec (63,57), top level with a three-stage pipeline.
// Depends on hsc_pkg, hsc_syndrome and hsc_resolve.
// Each request carries an operation in tuser: encode a data word or decode and correct a
// received word. One request is taken every clock cycle while the sink is ready. Its result
// is registered in each stage in turn before it is offered on the master side. The three
// stages are input capture and bit placement, the parity XOR trees, and parity insertion or
// single-bit correction with data extraction. A stage takes a new request whenever it is
// empty or its contents move on, so m_axis_tready reaches s_axis_tready through a short
// combinational ready chain. Double errors are silently miscorrected.
`default_nettype none

module hamming_sec_codec (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [56:0] data_word, [119:57] received_word
  input  logic [hsc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // [0] operation
  input  logic [0:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [62:0] code_word, [119:63] data_out, [125:120] syndrome, [127:126] zero
  output logic [hsc_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

  logic                         v1_q, v2_q, v3_q;
  logic                         rdy1, rdy2, rdy3;
  hsc_pkg::item_t               s1_d, s1_q, s2_q;
  logic [hsc_pkg::SYN_W-1:0]    syn2_d, syn2_q;
  hsc_pkg::result_t             res3_d, res3_q;
  logic [hsc_pkg::DATA_W-1:0]   in_data;
  logic [hsc_pkg::CODE_W-1:0]   in_rx;

  assign rdy3 = !v3_q || m_axis_tready;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign s_axis_tready = rdy1;

  assign in_data = s_axis_tdata[hsc_pkg::DATA_W-1:0];
  assign in_rx   = s_axis_tdata[hsc_pkg::DATA_W +: hsc_pkg::CODE_W];

  always_comb begin
    s1_d.op = hsc_pkg::op_e'(s_axis_tuser[0]);
    if (s1_d.op == hsc_pkg::OP_DECODE) begin
      s1_d.word = in_rx & hsc_pkg::code_mask();
    end else begin
      s1_d.word = hsc_pkg::scatter(in_data);
    end
  end

  hsc_syndrome u_hsc_syndrome (
    .item_i (s1_q),
    .syn_o  (syn2_d)
  );

  hsc_resolve u_hsc_resolve (
    .item_i (s2_q),
    .syn_i  (syn2_q),
    .res_o  (res3_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= s_axis_tvalid;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && s_axis_tvalid) begin
      s1_q <= s1_d;
    end
    if (rdy2 && v1_q) begin
      s2_q   <= s1_q;
      syn2_q <= syn2_d;
    end
    if (rdy3 && v2_q) begin
      res3_q <= res3_d;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {{hsc_pkg::M_PAD_W{1'b0}}, res3_q};

endmodule

`default_nettype wire

// ===== rtl/core/hsc_syndrome.sv =====
// Parity check unit of the Hamming codec: one XOR tree per parity bit.
// Depends on hsc_pkg.
`default_nettype none

module hsc_syndrome (
  input  hsc_pkg::item_t             item_i,
  output logic [hsc_pkg::SYN_W-1:0]  syn_o
);

  // On encode the parity positions are still zero, so the same trees give
  // the parity bits; on decode they give the syndrome.
  always_comb begin
    syn_o = '0;
    for (int j = 0; j < hsc_pkg::PARITY_BITS; j++) begin
      syn_o[j] = ^(item_i.word & hsc_pkg::par_mask(j));
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hsc_resolve.sv =====
// Final stage of the Hamming codec: inserts parity or corrects one bit, then extracts data.
// Depends on hsc_pkg.
`default_nettype none

module hsc_resolve (
  input  hsc_pkg::item_t             item_i,
  input  logic [hsc_pkg::SYN_W-1:0]  syn_i,
  output hsc_pkg::result_t           res_o
);

  logic [hsc_pkg::CODE_W-1:0] cw;

  always_comb begin
    cw = item_i.word;
    if (item_i.op == hsc_pkg::OP_ENCODE) begin
      for (int j = 0; j < hsc_pkg::PARITY_BITS; j++) begin
        cw[(1 << j) - 1] = syn_i[j];
      end
    end else begin
      // A zero syndrome matches no position, so nothing is flipped.
      for (int i = 0; i < hsc_pkg::CODE_W; i++) begin
        cw[i] = item_i.word[i] ^ (syn_i == hsc_pkg::SYN_W'(i + 1));
      end
    end
  end

  always_comb begin
    res_o.code_word = cw;
    if (item_i.op == hsc_pkg::OP_ENCODE) begin
      res_o.data_out = '0;
      res_o.syndrome = '0;
    end else begin
      res_o.data_out = hsc_pkg::extract(cw);
      res_o.syndrome = syn_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hsc_checker.sv =====
// Port-level checker for the Hamming codec, attached to the top level by bind.
// Depends on hsc_pkg and hamming_sec_codec_defines.svh.
`default_nettype none

`include "hamming_sec_codec_defines.svh"

module hsc_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [hsc_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

  logic s_fire;
  logic m_stall;

  assign s_fire  = s_axis_tvalid && s_axis_tready;
  assign m_stall = m_axis_tvalid && !m_axis_tready;

  // A stalled result must stay put.
  `HSC_ASSERT_NEXT(a_out_hold, m_stall, m_axis_tvalid && $stable(m_axis_tdata), "result not held")

  // With the output stage free, no stage behind it can be blocking.
  `HSC_ASSERT_SAME(a_empty_out_ready, !m_axis_tvalid, s_axis_tready, "input stalled when empty")

  // A ready sink keeps the whole pipeline flowing.
  `HSC_ASSERT_SAME(a_sink_ready, m_axis_tready, s_axis_tready, "input stalled with ready sink")

  // A result appearing from idle must come from a request that passed through the stage registers.
  `HSC_ASSERT_SAME(a_latency, $rose(m_axis_tvalid), $past(s_fire, 3), "result without a request")

endmodule

bind hamming_sec_codec hsc_checker u_hsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== sim/hamming_sec_codec_checker.sv =====
// Result checker for the Hamming codec: predicts each response from the accepted requests.
// Holds a small package of codeword helpers that the stimulus shares. Depends on hsc_pkg.
`timescale 1ns / 1ps

package hsc_model_pkg;
  import hsc_pkg::*;

  // Positions 1..CODE_LEN that take part in the code.
  localparam logic [CODE_W-1:0] USED_POS = {CODE_W{1'b1}} >> (CODE_W - CODE_LEN);

  function automatic logic [SYN_W-1:0] code_syndrome(logic [CODE_W-1:0] word);
    logic [SYN_W-1:0] syn;
    syn = '0;
    for (int pos = 1; pos <= CODE_LEN; pos++) begin
      if (word[pos-1]) begin
        syn ^= SYN_W'(pos);
      end
    end
    return syn;
  endfunction

  function automatic logic [CODE_W-1:0] code_encode(logic [DATA_W-1:0] data);
    logic [CODE_W-1:0] cw;
    logic [SYN_W-1:0]  par;
    int                k;
    cw = '0;
    k  = 0;
    for (int pos = 1; pos <= CODE_LEN; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        cw[pos-1] = data[k];
        k++;
      end
    end
    // With the parity positions still clear, bit j of the syndrome is parity bit j.
    par = code_syndrome(cw);
    for (int j = 0; j < PARITY_BITS; j++) begin
      cw[(1 << j) - 1] = par[j];
    end
    return cw;
  endfunction

  function automatic logic [DATA_W-1:0] code_extract(logic [CODE_W-1:0] cw);
    logic [DATA_W-1:0] data;
    int                k;
    data = '0;
    k    = 0;
    for (int pos = 1; pos <= CODE_LEN; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        data[k] = cw[pos-1];
        k++;
      end
    end
    return data;
  endfunction

endpackage

module hamming_sec_codec_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  input  logic                          req_ready_i,
  input  logic [hsc_pkg::S_TDATA_W-1:0] req_data_i,
  input  logic [0:0]                    req_op_i,
  input  logic                          rsp_valid_i,
  input  logic                          rsp_ready_i,
  input  logic [hsc_pkg::M_TDATA_W-1:0] rsp_data_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import hsc_pkg::*;
  import hsc_model_pkg::*;

  result_t expected_results[$];
  int      mismatches = 0;

  function automatic result_t codec_outcome(op_e op, logic [DATA_W-1:0] data,
                                            logic [CODE_W-1:0] rx);
    result_t           r;
    logic [CODE_W-1:0] word;
    r = '0;
    if (op == OP_ENCODE) begin
      r.code_word = code_encode(data);
    end else begin
      word       = rx & USED_POS;
      r.syndrome = code_syndrome(word);
      // Any nonzero syndrome is taken as a single error, so double errors are miscorrected.
      if (r.syndrome != '0) begin
        word ^= CODE_W'(1) << (r.syndrome - 1);
      end
      r.code_word = word;
      r.data_out  = code_extract(word);
    end
    return r;
  endfunction

  task automatic report_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (req_valid_i && req_ready_i) begin
        expected_results.push_back(codec_outcome(op_e'(req_op_i[0]), req_data_i[DATA_W-1:0],
                                                 req_data_i[DATA_W +: CODE_W]));
      end
      if (rsp_valid_i && rsp_ready_i) begin
        got = result_t'(rsp_data_i[CODE_W+DATA_W+SYN_W-1:0]);
        if (expected_results.size() == 0) begin
          $display("%0t: response with no request outstanding, expected none, got %h",
                   $realtime, rsp_data_i);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          report_field("code_word", 64'(want.code_word), 64'(got.code_word));
          report_field("data_out", 64'(want.data_out), 64'(got.data_out));
          report_field("syndrome", 64'(want.syndrome), 64'(got.syndrome));
          report_field("padding", 64'd0, 64'(rsp_data_i[M_TDATA_W-1 -: M_PAD_W]));
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_results.size();
  end

endmodule

// ===== sim/hamming_sec_codec_tb.sv =====
// Testbench top for the Hamming codec: directed and random encode and decode requests.
// Depends on hsc_pkg, hamming_sec_codec and hamming_sec_codec_checker with its package.
`timescale 1ns / 1ps

module hamming_sec_codec_tb;
  import hsc_pkg::*;
  import hsc_model_pkg::*;

  localparam int RANDOM_ITEMS = 1100;
  localparam int QUIET_LIMIT  = 2000;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [0:0]           s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  int                   fail_count;
  int                   outstanding;
  logic                 steady        = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  hamming_sec_codec u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  hamming_sec_codec_checker u_result_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_i  (s_axis_tready),
    .req_data_i   (s_axis_tdata),
    .req_op_i     (s_axis_tuser),
    .rsp_valid_i  (m_axis_tvalid),
    .rsp_ready_i  (m_axis_tready),
    .rsp_data_i   (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (outstanding)
  );

  // The response side stalls about a quarter of the time, except during the steady stretch.
  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 23);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAILURE");
    $finish;
  end

  // Mostly dense random words, now and then all zeros, all ones or a lone bit.
  function automatic logic [63:0] random_pattern();
    logic [63:0] w;
    case ($urandom_range(9))
      0:       w = '0;
      1:       w = '1;
      2:       w = 64'd1 << $urandom_range(63);
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  // Idle cycles carry junk on tdata and tuser, which the block must not take.
  task automatic send_request(input op_e op, input logic [DATA_W-1:0] data,
                              input logic [CODE_W-1:0] rx);
    while (!steady && $urandom_range(99) < 23) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= S_TDATA_W'({$urandom, $urandom, $urandom, $urandom});
      s_axis_tuser  <= 1'($urandom);
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {rx, data};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  initial begin
    logic [CODE_W-1:0] cw;
    logic [DATA_W-1:0] data;
    logic [63:0]       pick;
    int                roll;
    int                pos_a;
    int                pos_b;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Extremes, lone bits, and the field that the operation leaves unused held at all ones.
    send_request(OP_ENCODE, '0, '0);
    send_request(OP_ENCODE, '1, '1);
    send_request(OP_ENCODE, DATA_W'(1), '0);
    send_request(OP_ENCODE, DATA_W'(1) << (DATA_W - 1), '0);
    send_request(OP_ENCODE, DATA_W'({29{2'b01}}), '0);
    send_request(OP_DECODE, '0, '0);
    send_request(OP_DECODE, '1, '1);
    send_request(OP_DECODE, '0, CODE_W'(1));
    send_request(OP_DECODE, '0, CODE_W'(1) << (CODE_LEN - 1));
    cw = code_encode(DATA_W'({29{2'b01}}));
    send_request(OP_DECODE, '0, cw);
    send_request(OP_DECODE, '0, cw ^ CODE_W'(1));
    send_request(OP_DECODE, '0, cw ^ (CODE_W'(1) << 31));
    send_request(OP_DECODE, '0, cw ^ (CODE_W'(1) << (CODE_LEN - 1)));
    send_request(OP_DECODE, '1, cw ^ (CODE_W'(1) << 4));
    // Two flipped bits are miscorrected and three pass as a codeword, with no flag; then one flip.
    send_request(OP_DECODE, '0, cw ^ CODE_W'(3));
    send_request(OP_DECODE, '0, cw ^ CODE_W'(7));
    send_request(OP_DECODE, '0, '1 ^ (CODE_W'(1) << 40));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 400 && n < 600);
      pick   = random_pattern();
      data   = pick[DATA_W-1:0];
      pick   = random_pattern();
      cw     = pick[CODE_W-1:0];
      if ($urandom_range(99) < 30) begin
        send_request(OP_ENCODE, data, cw);
      end else begin
        // Most decode requests are valid codewords with zero, one or two bits flipped.
        roll = $urandom_range(19);
        if (roll < 19) begin
          cw = code_encode(data);
        end
        if (roll >= 7 && roll < 19) begin
          pos_a     = $urandom_range(CODE_LEN - 1);
          cw[pos_a] = ~cw[pos_a];
        end
        if (roll >= 16 && roll < 19) begin
          pos_b     = (pos_a + 1 + $urandom_range(CODE_LEN - 2)) % CODE_LEN;
          cw[pos_b] = ~cw[pos_b];
        end
        pick = random_pattern();
        send_request(OP_DECODE, pick[DATA_W-1:0], cw);
      end
    end
    steady = 1'b0;

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== hamming_sec_codec.f =====
+incdir+rtl/core
rtl/core/hsc_pkg.sv
rtl/core/hsc_syndrome.sv
rtl/core/hsc_resolve.sv
rtl/core/hamming_sec_codec.sv
rtl/core/hsc_checker.sv
sim/hamming_sec_codec_checker.sv
sim/hamming_sec_codec_tb.sv
